@@ design/spbbd_pkg.sv @@
// Shared types and constants for the smoothed position bang-bang drive unit.
package spbbd_pkg;

  localparam int unsigned SampleW = 10;
  localparam int unsigned BandW   = 10;
  localparam int unsigned DeadW   = 8;
  localparam int unsigned DutyW   = 8;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 10;
  localparam int unsigned InTdataW  = 16;
  localparam int unsigned OutTdataW = 24;

  // Register indexes on the configuration channel.
  localparam logic [CfgIdxW-1:0] RegTarget   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegDeadband = 3'd1;
  localparam logic [CfgIdxW-1:0] RegFastBand = 3'd2;
  localparam logic [CfgIdxW-1:0] RegSlowBand = 3'd3;
  localparam logic [CfgIdxW-1:0] RegFastDuty = 3'd4;
  localparam logic [CfgIdxW-1:0] RegSlowDuty = 3'd5;

  // Register reset values.
  localparam logic [SampleW-1:0] TargetRst   = 10'd127;
  localparam logic [DeadW-1:0]   DeadbandRst = 8'd5;
  localparam logic [BandW-1:0]   FastBandRst = 10'd15;
  localparam logic [BandW-1:0]   SlowBandRst = 10'd5;
  localparam logic [DutyW-1:0]   FastDutyRst = 8'd255;
  localparam logic [DutyW-1:0]   SlowDutyRst = 8'd150;

  typedef struct packed {
    logic [SampleW-1:0] target;
    logic [DeadW-1:0]   deadband;
    logic [BandW-1:0]   fast_band;
    logic [BandW-1:0]   slow_band;
    logic [DutyW-1:0]   fast_duty;
    logic [DutyW-1:0]   slow_duty;
  } cfg_t;

endpackage

@@ design/spbbd_cell.sv @@
// One window cell: holds a sample and hands it to the next cell on each shift.
module spbbd_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          shift_i,
  input  logic [spbbd_pkg::SampleW-1:0] sample_i,
  output logic [spbbd_pkg::SampleW-1:0] sample_o
);
  import spbbd_pkg::*;

  logic [SampleW-1:0] sample_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_q <= '0;
    end else if (shift_i) begin
      sample_q <= sample_i;
    end
  end

  assign sample_o = sample_q;

endmodule

@@ design/spbbd_div.sv @@
// Two-stage divide of the window total by the window length (reciprocal multiply).
module spbbd_div #(
  parameter int unsigned WINDOW = 50
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        in_valid_i,
  output logic                                        in_ready_o,
  input  logic [$clog2(WINDOW*1023+1)-1:0]            total_i,
  output logic                                        out_valid_o,
  input  logic                                        out_ready_i,
  output logic [spbbd_pkg::SampleW-1:0]               avg_o
);
  import spbbd_pkg::*;

  localparam int unsigned TotW  = $clog2(WINDOW*1023+1);
  localparam int unsigned Shift = TotW;
  localparam int unsigned RecW  = Shift + 1;
  localparam int unsigned ProdW = TotW + RecW;
  localparam logic [RecW-1:0] Recip = RecW'((2**Shift) / WINDOW);
  localparam logic [TotW-1:0] WinT  = TotW'(WINDOW);

  logic             mul_valid_q;
  logic [ProdW-1:0] prod_q;
  logic [TotW-1:0]  total_q;
  logic             mul_ready;

  logic               avg_valid_q;
  logic [SampleW-1:0] avg_q;
  logic [SampleW-1:0] q_est;
  logic [TotW-1:0]    rem;
  logic [SampleW-1:0] avg_d;

  assign mul_ready  = !avg_valid_q || out_ready_i;
  assign in_ready_o = !mul_valid_q || mul_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      mul_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      prod_q  <= ProdW'(total_i) * ProdW'(Recip);
      total_q <= total_i;
    end
  end

  // The estimate is low by at most one; fix it with one compare on the remainder.
  always_comb begin
    q_est = prod_q[Shift +: SampleW];
    rem   = total_q - TotW'(q_est) * WinT;
    avg_d = (rem >= WinT) ? q_est + SampleW'(1) : q_est;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      avg_valid_q <= 1'b0;
    end else if (mul_ready) begin
      avg_valid_q <= mul_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mul_ready && mul_valid_q) begin
      avg_q <= avg_d;
    end
  end

  assign out_valid_o = avg_valid_q;
  assign avg_o       = avg_q;

  ap_quot_exact: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_valid_q |-> (TotW'(avg_d) * WinT <= total_q) &&
                    (total_q - TotW'(avg_d) * WinT < WinT))
    else $error("corrected quotient is not the floor of the window total");

  ap_avg_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    avg_valid_q && !out_ready_i |=> avg_valid_q && $stable(avg_q))
    else $error("quotient changed while stalled");

endmodule

@@ design/spbbd_decide.sv @@
// Direction hysteresis and duty band selection, with the result register.
module spbbd_decide (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  spbbd_pkg::cfg_t               cfg_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [spbbd_pkg::SampleW-1:0] avg_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [spbbd_pkg::SampleW-1:0] avg_o,
  output logic                          cw_o,
  output logic                          ccw_o,
  output logic [spbbd_pkg::DutyW-1:0]   duty_o
);
  import spbbd_pkg::*;

  localparam int unsigned CmpW = SampleW + 2;

  logic               valid_q;
  logic [SampleW-1:0] avg_q;
  logic               cw_q;
  logic               ccw_q;
  logic [DutyW-1:0]   duty_q;
  logic               cw_d;
  logic               ccw_d;
  logic [DutyW-1:0]   duty_d;

  logic signed [CmpW-1:0] avg_s;
  logic signed [CmpW-1:0] tgt_s;
  logic signed [CmpW-1:0] lo_s;
  logic signed [CmpW-1:0] hi_s;
  logic signed [CmpW-1:0] diff_s;
  logic [SampleW-1:0]     err;

  assign in_ready_o = !valid_q || out_ready_i;

  always_comb begin
    avg_s  = signed'(CmpW'(avg_i));
    tgt_s  = signed'(CmpW'(cfg_i.target));
    lo_s   = tgt_s - signed'(CmpW'(cfg_i.deadband));
    hi_s   = tgt_s + signed'(CmpW'(cfg_i.deadband));
    diff_s = avg_s - tgt_s;
    err    = diff_s[CmpW-1] ? SampleW'(-diff_s) : SampleW'(diff_s);

    // Hold the previous direction inside the hysteresis window.
    cw_d  = cw_q;
    ccw_d = ccw_q;
    if (avg_s < lo_s) begin
      cw_d  = 1'b1;
      ccw_d = 1'b0;
    end else if (avg_s > hi_s) begin
      cw_d  = 1'b0;
      ccw_d = 1'b1;
    end

    if (err > cfg_i.fast_band) begin
      duty_d = cfg_i.fast_duty;
    end else if (err > cfg_i.slow_band) begin
      duty_d = cfg_i.slow_duty;
    end else begin
      duty_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      cw_q    <= 1'b0;
      ccw_q   <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
      if (in_valid_i) begin
        cw_q  <= cw_d;
        ccw_q <= ccw_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      avg_q  <= avg_i;
      duty_q <= duty_d;
    end
  end

  assign out_valid_o = valid_q;
  assign avg_o       = avg_q;
  assign cw_o        = cw_q;
  assign ccw_o       = ccw_q;
  assign duty_o      = duty_q;

endmodule

@@ design/smoothed_position_bang_bang_drive_unit.sv @@
// Top level of the smoothed position bang-bang drive unit.
//
// Each input transaction carries one converter sample. The samples shift through a chain of
// WINDOW cells (cleared to zero at reset) while a running total is updated by adding the new
// sample and dropping the one leaving the last cell. The total is divided by WINDOW in two
// stages, then the hysteresis and duty bands are applied in the result register. The unit
// takes one sample per clock cycle sustained while the result side keeps tready high; an
// accepted sample loads the first of four registered stages (total, reciprocal product,
// corrected quotient, decision) on the accepting edge. Back pressure on the result side
// stalls only the stages behind a full one. Configuration writes are accepted at any time
// and must be issued while the unit is idle; indexes beyond the register list are ignored.
module smoothed_position_bang_bang_drive_unit #(
  parameter int unsigned WINDOW = 50
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // tdata: [9:0] position_sample
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [spbbd_pkg::InTdataW-1:0]    s_axis_tdata,
  // tdata: [9:0] smoothed_position, [10] drive_cw, [11] drive_ccw, [19:12] duty
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [spbbd_pkg::OutTdataW-1:0]   m_axis_tdata,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [spbbd_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [spbbd_pkg::CfgDatW-1:0]     cfg_data_i
);
  import spbbd_pkg::*;

  localparam int unsigned TotW = $clog2(WINDOW*1023+1);
  localparam logic [TotW-1:0] TotMax = TotW'(WINDOW*1023);

  cfg_t cfg_q;

  logic [SampleW-1:0] chain [WINDOW+1];
  logic               accept;
  logic               tot_valid_q;
  logic [TotW-1:0]    total_q;
  logic               div_ready;
  logic               div_valid;
  logic [SampleW-1:0] div_avg;
  logic               dec_ready;
  logic [SampleW-1:0] res_avg;
  logic               res_cw;
  logic               res_ccw;
  logic [DutyW-1:0]   res_duty;

  // Configuration registers.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target    <= TargetRst;
      cfg_q.deadband  <= DeadbandRst;
      cfg_q.fast_band <= FastBandRst;
      cfg_q.slow_band <= SlowBandRst;
      cfg_q.fast_duty <= FastDutyRst;
      cfg_q.slow_duty <= SlowDutyRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegTarget:   cfg_q.target    <= cfg_data_i;
        RegDeadband: cfg_q.deadband  <= cfg_data_i[DeadW-1:0];
        RegFastBand: cfg_q.fast_band <= cfg_data_i;
        RegSlowBand: cfg_q.slow_band <= cfg_data_i;
        RegFastDuty: cfg_q.fast_duty <= cfg_data_i[DutyW-1:0];
        RegSlowDuty: cfg_q.slow_duty <= cfg_data_i[DutyW-1:0];
        default: ;
      endcase
    end
  end

  // Sample window.
  assign s_axis_tready = !tot_valid_q || div_ready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign chain[0]      = s_axis_tdata[SampleW-1:0];

  for (genvar g = 0; g < WINDOW; g++) begin : g_cell
    spbbd_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .shift_i  (accept),
      .sample_i (chain[g]),
      .sample_o (chain[g+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tot_valid_q <= 1'b0;
      total_q     <= '0;
    end else begin
      if (s_axis_tready) begin
        tot_valid_q <= s_axis_tvalid;
      end
      if (accept) begin
        // Add the new sample, drop the one leaving the last cell.
        total_q <= total_q - TotW'(chain[WINDOW]) + TotW'(chain[0]);
      end
    end
  end

  spbbd_div #(
    .WINDOW (WINDOW)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (tot_valid_q),
    .in_ready_o  (div_ready),
    .total_i     (total_q),
    .out_valid_o (div_valid),
    .out_ready_i (dec_ready),
    .avg_o       (div_avg)
  );

  spbbd_decide u_decide (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (div_valid),
    .in_ready_o  (dec_ready),
    .avg_i       (div_avg),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .avg_o       (res_avg),
    .cw_o        (res_cw),
    .ccw_o       (res_ccw),
    .duty_o      (res_duty)
  );

  assign m_axis_tdata = {{(OutTdataW-SampleW-2-DutyW){1'b0}}, res_duty, res_ccw, res_cw,
                         res_avg};

  ap_dir_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(res_cw && res_ccw))
    else $error("both drive directions enabled");

  ap_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= TotMax)
    else $error("window total out of range");

  ap_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !tot_valid_q |-> s_axis_tready)
    else $error("input stalled with empty total stage");

  ap_dir_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(div_valid && dec_ready) |=> $stable(res_cw) && $stable(res_ccw))
    else $error("direction changed without a transaction");

endmodule

@@ tb/smoothed_position_bang_bang_drive_unit_test.sv @@
// Self-checking testbench for the smoothed position bang-bang drive unit.
module smoothed_position_bang_bang_drive_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import spbbd_pkg::*;

  localparam int unsigned Window        = 50;
  localparam int unsigned PhaseItems    = 290;
  localparam int unsigned DrainCycles   = 8;
  localparam int unsigned HoldOffCycles = 300;
  localparam int unsigned WatchdogLimit = 5000;

  // Indexes past the register list; writes to them must have no effect.
  localparam logic [CfgIdxW-1:0] RegBeyondLo = 3'd6;
  localparam logic [CfgIdxW-1:0] RegBeyondHi = 3'd7;

  typedef struct packed {
    logic [SampleW-1:0] position;
    logic               cw;
    logic               ccw;
    logic [DutyW-1:0]   duty;
  } drive_result_t;

  class drive_scoreboard;
    logic [SampleW-1:0] target;
    logic [DeadW-1:0]   deadband;
    logic [BandW-1:0]   fast_band;
    logic [BandW-1:0]   slow_band;
    logic [DutyW-1:0]   fast_duty;
    logic [DutyW-1:0]   slow_duty;
    logic [SampleW-1:0] sample_ring [Window];
    int unsigned        running_total;
    int unsigned        slot;
    logic               cw_on;
    logic               ccw_on;
    drive_result_t      expected_drive_q [$];
    int unsigned        fail_count;

    function new();
      target    = TargetRst;
      deadband  = DeadbandRst;
      fast_band = FastBandRst;
      slow_band = SlowBandRst;
      fast_duty = FastDutyRst;
      slow_duty = SlowDutyRst;
      foreach (sample_ring[i]) sample_ring[i] = '0;
      running_total = 0;
      slot          = 0;
      cw_on         = 1'b0;
      ccw_on        = 1'b0;
      fail_count    = 0;
    endfunction

    function void apply_register(logic [CfgIdxW-1:0] idx, logic [CfgDatW-1:0] data);
      case (idx)
        RegTarget:   target    = data[SampleW-1:0];
        RegDeadband: deadband  = data[DeadW-1:0];
        RegFastBand: fast_band = data[BandW-1:0];
        RegSlowBand: slow_band = data[BandW-1:0];
        RegFastDuty: fast_duty = data[DutyW-1:0];
        RegSlowDuty: slow_duty = data[DutyW-1:0];
        default: ;
      endcase
    endfunction

    function drive_result_t predict_drive(logic [SampleW-1:0] sample);
      drive_result_t r;
      int avg;
      int tgt;
      int dead;
      int err;
      running_total = running_total - sample_ring[slot] + sample;
      sample_ring[slot] = sample;
      slot = (slot == Window - 1) ? 0 : slot + 1;
      avg  = running_total / Window;
      tgt  = int'(target);
      dead = int'(deadband);
      // Compare signed so bounds outside the code range are never crossed.
      if (avg < tgt - dead) begin
        cw_on  = 1'b1;
        ccw_on = 1'b0;
      end else if (avg > tgt + dead) begin
        cw_on  = 1'b0;
        ccw_on = 1'b1;
      end
      err = (avg < tgt) ? tgt - avg : avg - tgt;
      if (err > int'(fast_band)) r.duty = fast_duty;
      else if (err > int'(slow_band)) r.duty = slow_duty;
      else r.duty = '0;
      r.position = avg[SampleW-1:0];
      r.cw       = cw_on;
      r.ccw      = ccw_on;
      return r;
    endfunction

    function void note_sample(logic [InTdataW-1:0] tdata);
      expected_drive_q.push_back(predict_drive(tdata[SampleW-1:0]));
    endfunction

    function void check_result(logic [OutTdataW-1:0] tdata);
      drive_result_t want;
      drive_result_t got;
      if (expected_drive_q.size() == 0) begin
        $display("%0t: result %h arrived with nothing expected", $time, tdata);
        fail_count++;
        return;
      end
      want         = expected_drive_q.pop_front();
      got.position = tdata[SampleW-1:0];
      got.cw       = tdata[SampleW];
      got.ccw      = tdata[SampleW+1];
      got.duty     = tdata[SampleW+2 +: DutyW];
      if (got.position !== want.position) begin
        $display("%0t: smoothed_position expected %0d actual %0d", $time, want.position,
                 got.position);
        fail_count++;
      end
      if (got.cw !== want.cw) begin
        $display("%0t: drive_cw expected %0b actual %0b", $time, want.cw, got.cw);
        fail_count++;
      end
      if (got.ccw !== want.ccw) begin
        $display("%0t: drive_ccw expected %0b actual %0b", $time, want.ccw, got.ccw);
        fail_count++;
      end
      if (got.duty !== want.duty) begin
        $display("%0t: duty expected %0d actual %0d", $time, want.duty, got.duty);
        fail_count++;
      end
    endfunction

    function int unsigned pending();
      return expected_drive_q.size();
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [InTdataW-1:0]  s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutTdataW-1:0] m_axis_tdata;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CfgIdxW-1:0]   cfg_index_i = '0;
  logic [CfgDatW-1:0]   cfg_data_i = '0;

  drive_scoreboard sb;
  int unsigned     src_idle_pct = 0;
  int unsigned     sink_idle_pct = 0;
  int unsigned     sink_hold_len = 0;
  int unsigned     hold_left = 0;
  int unsigned     quiet_cycles = 0;
  int              level = 0;
  int unsigned     level_left = 0;

  // Full-scale burst drives the average past the upper bound, then zeros hold it.
  logic [InTdataW-1:0] directed_samples [24] = '{
    16'h0000, 16'hFC00, 16'h03FF, 16'hFFFF, 16'h0155, 16'hAAAA, 16'h03FF, 16'h03FF,
    16'h7FFF, 16'h03FF, 16'h83FF, 16'h03FF, 16'h03FF, 16'h0200, 16'h01FF, 16'h0000,
    16'h0000, 16'hFC00, 16'h0000, 16'h0000, 16'h0001, 16'h0000, 16'h0000, 16'h0000
  };

  smoothed_position_bang_bang_drive_unit #(
    .WINDOW(Window)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Result side: check each transaction, then pick tready for the next cycle.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    if (sink_hold_len != 0) begin
      hold_left     = sink_hold_len;
      sink_hold_len = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WatchdogLimit) begin
          $display("smoothed_position_bang_bang_drive_unit verification failed");
          $finish;
        end
      end
    end
  end

  // Mostly a drifting level with small noise, so the average settles and
  // crosses the hysteresis bounds; the rest is full-range noise.
  function automatic logic [InTdataW-1:0] next_sample();
    int         s;
    logic [5:0] upper;
    if (level_left == 0) begin
      if ($urandom_range(99) < 30) level = int'(sb.target) + int'($urandom_range(120)) - 60;
      else level = $urandom_range(1023);
      level_left = $urandom_range(120, 20);
    end
    level_left--;
    if ($urandom_range(99) < 20) s = $urandom_range(1023);
    else s = level + int'($urandom_range(40)) - 20;
    if (s < 0) s = 0;
    if (s > 1023) s = 1023;
    upper = 6'($urandom());
    return {upper, s[SampleW-1:0]};
  endfunction

  task automatic send_sample(logic [InTdataW-1:0] data);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_sample(data);
  endtask

  task automatic load_register(logic [CfgIdxW-1:0] idx, logic [CfgDatW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.apply_register(idx, data);
  endtask

  task automatic program_setting(logic [CfgDatW-1:0] tgt, logic [CfgDatW-1:0] dead,
                                 logic [CfgDatW-1:0] fband, logic [CfgDatW-1:0] sband,
                                 logic [CfgDatW-1:0] fduty, logic [CfgDatW-1:0] sduty);
    load_register(RegTarget, tgt);
    load_register(RegDeadband, dead);
    load_register(RegFastBand, fband);
    load_register(RegSlowBand, sband);
    load_register(RegFastDuty, fduty);
    load_register(RegSlowDuty, sduty);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  initial begin
    sb = new();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    src_idle_pct  = 12;
    sink_idle_pct = 86;
    foreach (directed_samples[i]) send_sample(directed_samples[i]);
    s_axis_tvalid <= 1'b0;

    for (int ph = 0; ph < 6; ph++) begin
      wait_drained();
      case (ph)
        0: program_setting(10'd300, 10'd20, 10'd40, 10'd10, 10'd255, 10'd100);
        // Deadband masked to 255 below a zero target: clockwise can never engage.
        1: program_setting(10'd0, 10'h3FF, 10'd0, 10'd0, 10'd0, 10'd255);
        // Top target with full bands: duty stays zero, counter-clockwise unreachable.
        2: program_setting(10'd1023, 10'd0, 10'd1023, 10'd1023, 10'h3FF, 10'd0);
        3: begin
          load_register(RegBeyondLo, 10'h3FF);
          load_register(RegBeyondHi, 10'h3FF);
          // Slow band above fast band: fast level still wins.
          program_setting(10'd512, 10'd3, 10'd4, 10'd600, 10'd200, 10'd77);
        end
        4: program_setting(10'd200, 10'd0, 10'd1, 10'd0, 10'd1, 10'd254);
        default: program_setting(10'($urandom_range(1023)), 10'($urandom()),
                                 10'($urandom_range(120)), 10'($urandom_range(120)),
                                 10'($urandom()), 10'($urandom()));
      endcase
      case (ph / 2)
        0: begin
          src_idle_pct  = 12;
          sink_idle_pct = 86;
        end
        1: begin
          src_idle_pct  = 86;
          sink_idle_pct = 12;
        end
        default: begin
          src_idle_pct  = 0;
          sink_idle_pct = 0;
        end
      endcase
      for (int i = 0; i < PhaseItems; i++) begin
        // Stall the result side long enough to back up the input.
        if (ph == 4 && i == 60) sink_hold_len = HoldOffCycles;
        send_sample(next_sample());
      end
      s_axis_tvalid <= 1'b0;
    end

    wait_drained();
    if (sb.fail_count == 0 && sb.pending() == 0) begin
      $display("smoothed_position_bang_bang_drive_unit verification clean");
    end else begin
      $display("smoothed_position_bang_bang_drive_unit verification failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/spbbd_pkg.sv
design/spbbd_cell.sv
design/spbbd_div.sv
design/spbbd_decide.sv
design/smoothed_position_bang_bang_drive_unit.sv
tb/smoothed_position_bang_bang_drive_unit_test.sv
